FILE: src/json_string_unescape_utf8_macros.svh
// Assertion macros shared by the checker of the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Implication into the next cycle, live through reset.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication, off while reset is high.
`define JSU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define JSU_ASSERT_HOLD(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/jsu_pkg.sv
// Types, constants and decode functions of the JSON string unescaper.
`default_nettype none

package jsu_pkg;

   // Result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
   localparam logic [2:0] ERR_BAD_ESC  = 3'd2;
   localparam logic [2:0] ERR_BAD_HEX  = 3'd3;
   localparam logic [2:0] ERR_ENDED    = 3'd4;

   // Characters with a meaning of their own
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U      = 8'h75;

   // Top six bits of a 16-bit surrogate
   localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
   localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

   localparam logic [20:0] SUPP_BASE = 21'h10000;

   // Command queue between front and back
   localparam int FIFO_AW    = 2;
   localparam int FIFO_DEPTH = 1 << FIFO_AW;

   typedef enum logic [1:0] {
      TERM_NONE,
      TERM_CLOSE,
      TERM_ERROR
   } term_type;

   // Everything one input byte produces: up to two code points, then a terminator.
   // A raw byte travels as a code point of length one.
   typedef struct packed {
      logic [20:0] a_cp;
      logic [2:0]  a_len;
      logic [20:0] b_cp;
      logic [1:0]  b_len;
      term_type    term;
      logic [2:0]  err;
   } jsu_cmd_type;

   // {valid, value} of a hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // {valid, byte} of a single-character escape
   function automatic logic [8:0] esc_decode(input logic [7:0] c);
      logic [8:0] r;
      unique case (c)
         8'h22:   r = {1'b1, 8'h22};
         8'h5C:   r = {1'b1, 8'h5C};
         8'h2F:   r = {1'b1, 8'h2F};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0C};
         8'h6E:   r = {1'b1, 8'h0A};
         8'h72:   r = {1'b1, 8'h0D};
         8'h74:   r = {1'b1, 8'h09};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // UTF-8 length of a code point
   function automatic logic [2:0] cp_len(input logic [20:0] cp);
      logic [2:0] r;
      if (cp <= 21'h7F) begin
         r = 3'd1;
      end else if (cp <= 21'h7FF) begin
         r = 3'd2;
      end else if (cp <= 21'hFFFF) begin
         r = 3'd3;
      end else begin
         r = 3'd4;
      end
      return r;
   endfunction

   // Byte at position pos of the UTF-8 form of cp, given its length
   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                            input logic [1:0] pos);
      logic [7:0] r;
      unique case (len)
         3'd2: begin
            r = (pos == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         end
         3'd3: begin
            unique case (pos)
               2'd0:    r = {4'b1110, cp[15:12]};
               2'd1:    r = {2'b10, cp[11:6]};
               default: r = {2'b10, cp[5:0]};
            endcase
         end
         3'd4: begin
            unique case (pos)
               2'd0:    r = {5'b11110, cp[20:18]};
               2'd1:    r = {2'b10, cp[17:12]};
               2'd2:    r = {2'b10, cp[11:6]};
               default: r = {2'b10, cp[5:0]};
            endcase
         end
         default: r = cp[7:0];
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: src/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper to UTF-8.
//
//   channel   direction  transfer when      payload
//   req       in         push && !full     req_in_byte, req_end_of_input
//   rsp       out        pop && !empty     rsp_out_byte, rsp_out_kind, rsp_err_code, rsp_last
//
// One input byte is taken per cycle while full is low; the front end decodes it in that cycle.
// A byte yields 0 to 7 results, which the back end issues one per cycle while pop stays
// high; a four-entry command queue absorbs bursts.
// Reset is synchronous and clears string state, queue and the output valid flag.
// full rises only when the command queue holds four commands; pop low holds the result.
`default_nettype none

module json_string_unescape_utf8 import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_out_kind,
   output logic [2:0] rsp_err_code,
   output logic       rsp_last
);

   logic        accept;
   logic        cmd_push;
   jsu_cmd_type cmd;
   jsu_cmd_type head;
   logic        head_valid;
   logic        head_pop;
   logic        q_full;

   assign accept = push && !q_full;
   assign full   = q_full;

   jsu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .end_of_input (req_end_of_input),
      .cmd_push     (cmd_push),
      .cmd          (cmd)
   );

   jsu_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (cmd_push),
      .wr_data   (cmd),
      .rd_en     (head_pop),
      .rd_data   (head),
      .not_empty (head_valid),
      .full      (q_full)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .empty      (empty),
      .pop        (pop),
      .out_byte   (rsp_out_byte),
      .out_kind   (rsp_out_kind),
      .err_code   (rsp_err_code),
      .last       (rsp_last)
   );

endmodule

`default_nettype wire

FILE: src/jsu_front.sv
// Front end: tracks string and escape state and turns each byte into at most one command.
`default_nettype none

module jsu_front import jsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  in_byte,
   input  logic        end_of_input,
   output logic        cmd_push,
   output jsu_cmd_type cmd
);

   typedef enum logic [2:0] {
      M_IDLE,
      M_STR,
      M_ESC,
      M_HEX,
      M_PEND,
      M_PEND_BS,
      M_LOWHEX
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [11:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [9:0]  hh_ff, hh_in;

   logic [4:0]  hex_res;
   logic [8:0]  esc_res;
   logic [15:0] full_val;
   logic [2:0]  v_len;
   logic [20:0] high_cp;
   logic [20:0] pair_cp;
   logic        v_is_high;
   logic        v_is_low;

   always_comb begin
      hex_res   = hex_digit(in_byte);
      esc_res   = esc_decode(in_byte);
      full_val  = {acc_ff, hex_res[3:0]};
      v_len     = cp_len({5'd0, full_val});
      high_cp   = {5'd0, SURR_HIGH_TAG, hh_ff};
      pair_cp   = SUPP_BASE + {1'b0, hh_ff, full_val[9:0]};
      v_is_high = (full_val[15:10] == SURR_HIGH_TAG);
      v_is_low  = (full_val[15:10] == SURR_LOW_TAG);

      mode_in = mode_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      hh_in   = hh_ff;
      cmd     = '{a_cp: 21'd0, a_len: 3'd0, b_cp: 21'd0, b_len: 2'd0,
                  term: TERM_NONE, err: ERR_NONE};

      unique case (mode_ff)
         M_IDLE: begin
            if (in_byte == CHAR_QUOTE) begin
               mode_in = M_STR;
            end else begin
               cmd.term = TERM_ERROR;
               cmd.err  = ERR_NO_QUOTE;
            end
         end
         M_STR: begin
            if (in_byte == CHAR_QUOTE) begin
               cmd.term = TERM_CLOSE;
               mode_in  = M_IDLE;
            end else if (in_byte == CHAR_BSLASH) begin
               mode_in = M_ESC;
            end else begin
               cmd.a_cp  = {13'd0, in_byte};
               cmd.a_len = 3'd1;
            end
         end
         M_ESC: begin
            if (esc_res[8]) begin
               cmd.a_cp  = {13'd0, esc_res[7:0]};
               cmd.a_len = 3'd1;
               mode_in   = M_STR;
            end else if (in_byte == CHAR_U) begin
               mode_in = M_HEX;
               acc_in  = 12'd0;
               cnt_in  = 2'd0;
            end else begin
               cmd.term = TERM_ERROR;
               cmd.err  = ERR_BAD_ESC;
               mode_in  = M_IDLE;
            end
         end
         M_HEX, M_LOWHEX: begin
            if (end_of_input && cnt_ff != 2'd3) begin
               // too short: a pending high half goes out alone, the end error follows
               if (mode_ff == M_LOWHEX) begin
                  cmd.a_cp  = high_cp;
                  cmd.a_len = 3'd3;
               end
            end else if (!hex_res[4]) begin
               cmd.term = TERM_ERROR;
               cmd.err  = ERR_BAD_HEX;
               mode_in  = M_IDLE;
            end else if (cnt_ff != 2'd3) begin
               acc_in = {acc_ff[7:0], hex_res[3:0]};
               cnt_in = cnt_ff + 2'd1;
            end else begin
               acc_in = 12'd0;
               cnt_in = 2'd0;
               if (mode_ff == M_LOWHEX && v_is_low) begin
                  cmd.a_cp  = pair_cp;
                  cmd.a_len = 3'd4;
                  hh_in     = 10'd0;
                  mode_in   = M_STR;
               end else if (mode_ff == M_HEX) begin
                  if (v_is_high) begin
                     // hold the high half until the bytes that follow show a pair or not
                     hh_in   = full_val[9:0];
                     mode_in = M_PEND;
                     if (end_of_input) begin
                        cmd.a_cp  = {5'd0, full_val};
                        cmd.a_len = 3'd3;
                     end
                  end else begin
                     cmd.a_cp  = {5'd0, full_val};
                     cmd.a_len = v_len;
                     mode_in   = M_STR;
                  end
               end else begin
                  // no pair: drop the old high half out, then treat the value afresh
                  cmd.a_cp  = high_cp;
                  cmd.a_len = 3'd3;
                  if (v_is_high) begin
                     hh_in   = full_val[9:0];
                     mode_in = M_PEND;
                     if (end_of_input) begin
                        cmd.b_cp  = {5'd0, full_val};
                        cmd.b_len = 2'd3;
                     end
                  end else begin
                     cmd.b_cp  = {5'd0, full_val};
                     cmd.b_len = v_len[1:0];
                     mode_in   = M_STR;
                  end
               end
            end
         end
         M_PEND: begin
            if (in_byte == CHAR_BSLASH && !end_of_input) begin
               mode_in = M_PEND_BS;
            end else begin
               cmd.a_cp  = high_cp;
               cmd.a_len = 3'd3;
               hh_in     = 10'd0;
               if (in_byte == CHAR_QUOTE) begin
                  cmd.term = TERM_CLOSE;
                  mode_in  = M_IDLE;
               end else if (in_byte == CHAR_BSLASH) begin
                  mode_in = M_ESC;
               end else begin
                  cmd.b_cp  = {13'd0, in_byte};
                  cmd.b_len = 2'd1;
                  mode_in   = M_STR;
               end
            end
         end
         M_PEND_BS: begin
            if (in_byte == CHAR_U && !end_of_input) begin
               mode_in = M_LOWHEX;
               acc_in  = 12'd0;
               cnt_in  = 2'd0;
            end else begin
               cmd.a_cp  = high_cp;
               cmd.a_len = 3'd3;
               hh_in     = 10'd0;
               if (esc_res[8]) begin
                  cmd.b_cp  = {13'd0, esc_res[7:0]};
                  cmd.b_len = 2'd1;
                  mode_in   = M_STR;
               end else if (in_byte == CHAR_U) begin
                  mode_in = M_HEX;
                  acc_in  = 12'd0;
                  cnt_in  = 2'd0;
               end else begin
                  cmd.term = TERM_ERROR;
                  cmd.err  = ERR_BAD_ESC;
                  mode_in  = M_IDLE;
               end
            end
         end
         default: begin
            mode_in = M_IDLE;
         end
      endcase

      // a string still open at the end of the text fails
      if (end_of_input && mode_in != M_IDLE) begin
         cmd.term = TERM_ERROR;
         cmd.err  = ERR_ENDED;
         mode_in  = M_IDLE;
      end

      if (mode_in == M_IDLE) begin
         acc_in = 12'd0;
         cnt_in = 2'd0;
         hh_in  = 10'd0;
      end

      cmd_push = accept && (cmd.a_len != 3'd0 || cmd.b_len != 2'd0 || cmd.term != TERM_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         acc_ff  <= 12'd0;
         cnt_ff  <= 2'd0;
         hh_ff   <= 10'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         hh_ff   <= hh_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/jsu_fifo.sv
// Short command queue between the front end and the result sequencer.
`default_nettype none

module jsu_fifo import jsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  jsu_cmd_type wr_data,
   input  logic        rd_en,
   output jsu_cmd_type rd_data,
   output logic        not_empty,
   output logic        full
);

   jsu_cmd_type          store_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + {{FIFO_AW{1'b0}}, wr_en} - {{FIFO_AW{1'b0}}, rd_en};
      rd_data   = store_ff[rd_ptr_ff];
      not_empty = (count_ff != '0);
      full      = (count_ff == (FIFO_AW + 1)'(FIFO_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

FILE: src/jsu_back.sv
// Back end: walks each queued command and issues its results one per cycle while pop stays high.
`default_nettype none

module jsu_back import jsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  jsu_cmd_type head,
   input  logic        head_valid,
   output logic        head_pop,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  out_byte,
   output logic [1:0]  out_kind,
   output logic [2:0]  err_code,
   output logic        last
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] kind_ff, kind_in;
   logic [2:0] code_ff, code_in;
   logic       last_ff, last_in;

   logic [3:0] idx_w;
   logic [3:0] ab_len;
   logic [3:0] total;
   logic [3:0] b_pos;
   logic       advance;

   always_comb begin
      idx_w   = {1'b0, idx_ff};
      ab_len  = {1'b0, head.a_len} + {2'b00, head.b_len};
      total   = ab_len + {3'b000, (head.term != TERM_NONE)};
      b_pos   = idx_w - {1'b0, head.a_len};
      advance = head_valid && (!valid_ff || pop);

      if (idx_w < {1'b0, head.a_len}) begin
         byte_in = utf8_byte(head.a_cp, head.a_len, idx_ff[1:0]);
         kind_in = KIND_BYTE;
         code_in = ERR_NONE;
      end else if (idx_w < ab_len) begin
         byte_in = utf8_byte(head.b_cp, {1'b0, head.b_len}, b_pos[1:0]);
         kind_in = KIND_BYTE;
         code_in = ERR_NONE;
      end else begin
         byte_in = 8'd0;
         kind_in = (head.term == TERM_CLOSE) ? KIND_CLOSE : KIND_ERROR;
         code_in = (head.term == TERM_CLOSE) ? ERR_NONE : head.err;
      end
      last_in = (idx_w + 4'd1 == total);

      // advance within the command; drop it from the queue on its final result
      head_pop = advance && last_in;
      if (advance) begin
         idx_in = last_in ? 3'd0 : idx_ff + 3'd1;
      end else begin
         idx_in = idx_ff;
      end
      valid_in = advance || (valid_ff && !pop);

      empty    = !valid_ff;
      out_byte = byte_ff;
      out_kind = kind_ff;
      err_code = code_ff;
      last     = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
         kind_ff <= kind_in;
         code_ff <= code_in;
         last_ff <= last_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/jsu_checker.sv
// Port-level checker of the JSON string unescaper, bound to the top level.
`default_nettype none

`include "json_string_unescape_utf8_macros.svh"

module jsu_checker import jsu_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_out_kind,
   input logic [2:0] rsp_err_code,
   input logic       rsp_last
);

   logic        shown;
   logic        is_err;
   logic        is_term;
   logic [13:0] rsp_word;

   assign shown    = !empty;
   assign is_err   = (rsp_out_kind == KIND_ERROR);
   assign is_term  = (rsp_out_kind != KIND_BYTE);
   assign rsp_word = {rsp_out_byte, rsp_out_kind, rsp_err_code, rsp_last};

   `JSU_ASSERT_NEXT(a_reset_clears, reset, empty && !full, "queues not clear after reset")

   `JSU_ASSERT_SAME(a_code_on_err, shown && !is_err, rsp_err_code == ERR_NONE, "stray code")

   `JSU_ASSERT_SAME(a_term_last, shown && is_term, rsp_out_byte == 8'd0 && rsp_last, "bad term")

   `JSU_ASSERT_HOLD(a_stall_holds, shown && !pop, shown && $stable(rsp_word), "stall not held")

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the JSON string unescaper: directed cases, back-pressure, random strings.
`timescale 1ns / 100ps

module tb_top;
   import jsu_pkg::*;

   localparam int LIMIT_CYCLES = 300000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 420;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEXT,
      ST_ESC,
      ST_HEX,
      ST_PEND,
      ST_PEND_BS,
      ST_LOWHEX
   } scan_mode_type;

   typedef enum logic [1:0] {
      RX_READY,
      RX_PATTERN,
      RX_RANDOM
   } rx_style_type;

   typedef struct {
      logic [7:0] data;
      logic [1:0] kind;
      logic [2:0] code;
      logic       last;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_input = 1'b0;
   logic       empty;
   logic       pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_out_kind;
   logic [2:0] rsp_err_code;
   logic       rsp_last;

   // Decoder state as the block should hold it
   scan_mode_type scan_mode = ST_IDLE;
   logic [15:0]   hex_acc = 16'h0000;
   logic [1:0]    hex_digits = 2'd0;
   logic [9:0]    pending_high = 10'h000;

   decoded_type decoded_expected[$];
   decoded_type step_out[$];

   int           fail_count = 0;
   int           items_sent = 0;
   int           cycle_count = 0;
   int           burst_left = 0;
   int           end_rate = 0;
   bit           tx_bursty = 1'b0;
   rx_style_type rx_style = RX_READY;
   logic [15:0]  rx_pattern = 16'hFFFF;
   logic [3:0]   rx_phase = 4'd0;
   logic         rx_hold = 1'b0;
   event         hold_trigger;

   logic [7:0] esc_chars [8] = '{CHAR_QUOTE, CHAR_BSLASH, "/", "b", "f", "n", "r", "t"};

   json_string_unescape_utf8 dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_err_code     (rsp_err_code),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- decoder model

   function automatic void clear_scan();
      scan_mode = ST_IDLE;
      hex_acc = 16'h0000;
      hex_digits = 2'd0;
      pending_high = 10'h000;
   endfunction

   function automatic void put_result(input logic [7:0] b, input logic [1:0] k,
                                      input logic [2:0] e);
      decoded_type r;
      r.data = b;
      r.kind = k;
      r.code = e;
      r.last = 1'b0;
      step_out = {step_out, r};
   endfunction

   function automatic void abort_string(input logic [2:0] e);
      put_result(8'h00, KIND_ERROR, e);
      clear_scan();
   endfunction

   function automatic void emit_cp(input int cp);
      if (cp <= 'h7F) begin
         put_result(8'(cp), KIND_BYTE, ERR_NONE);
      end else if (cp <= 'h7FF) begin
         put_result(8'('hC0 | (cp >> 6)), KIND_BYTE, ERR_NONE);
         put_result(8'('h80 | (cp & 'h3F)), KIND_BYTE, ERR_NONE);
      end else if (cp <= 'hFFFF) begin
         put_result(8'('hE0 | (cp >> 12)), KIND_BYTE, ERR_NONE);
         put_result(8'('h80 | ((cp >> 6) & 'h3F)), KIND_BYTE, ERR_NONE);
         put_result(8'('h80 | (cp & 'h3F)), KIND_BYTE, ERR_NONE);
      end else begin
         put_result(8'('hF0 | (cp >> 18)), KIND_BYTE, ERR_NONE);
         put_result(8'('h80 | ((cp >> 12) & 'h3F)), KIND_BYTE, ERR_NONE);
         put_result(8'('h80 | ((cp >> 6) & 'h3F)), KIND_BYTE, ERR_NONE);
         put_result(8'('h80 | (cp & 'h3F)), KIND_BYTE, ERR_NONE);
      end
   endfunction

   function automatic void emit_high();
      emit_cp('hD800 + int'(pending_high));
   endfunction

   function automatic int hex_val(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   // Complete \u value outside a pair: open a pair or emit it
   function automatic void take_value(input logic [15:0] v);
      hex_acc = 16'h0000;
      hex_digits = 2'd0;
      if (v >= 16'hD800 && v <= 16'hDBFF) begin
         pending_high = v[9:0];
         scan_mode = ST_PEND;
      end else begin
         emit_cp(int'(v));
         scan_mode = ST_TEXT;
      end
   endfunction

   function automatic void in_text(input logic [7:0] c);
      if (c == CHAR_QUOTE) begin
         put_result(8'h00, KIND_CLOSE, ERR_NONE);
         clear_scan();
      end else if (c == CHAR_BSLASH) begin
         scan_mode = ST_ESC;
      end else begin
         put_result(c, KIND_BYTE, ERR_NONE);
      end
   endfunction

   function automatic void in_escape(input logic [7:0] c);
      logic [7:0] d;
      bit         ok;
      ok = 1'b1;
      d = 8'h00;
      case (c)
         CHAR_QUOTE:  d = CHAR_QUOTE;
         CHAR_BSLASH: d = CHAR_BSLASH;
         "/":         d = "/";
         "b":         d = 8'h08;
         "f":         d = 8'h0C;
         "n":         d = 8'h0A;
         "r":         d = 8'h0D;
         "t":         d = 8'h09;
         CHAR_U: begin
            scan_mode = ST_HEX;
            hex_acc = 16'h0000;
            hex_digits = 2'd0;
            ok = 1'b0;
         end
         default: begin
            abort_string(ERR_BAD_ESC);
            ok = 1'b0;
         end
      endcase
      if (ok) begin
         put_result(d, KIND_BYTE, ERR_NONE);
         scan_mode = ST_TEXT;
      end
   endfunction

   function automatic void unescape_byte(input logic [7:0] c, input bit fin);
      int h;
      step_out.delete();
      case (scan_mode)
         ST_IDLE: begin
            if (c == CHAR_QUOTE) scan_mode = ST_TEXT;
            else abort_string(ERR_NO_QUOTE);
         end
         ST_TEXT: in_text(c);
         ST_ESC:  in_escape(c);
         ST_HEX, ST_LOWHEX: begin
            h = hex_val(c);
            // a short escape at the end of input is reported below
            if (!(fin && hex_digits < 2'd3)) begin
               if (h < 0) begin
                  abort_string(ERR_BAD_HEX);
               end else begin
                  hex_acc = {hex_acc[11:0], 4'(h)};
                  if (hex_digits < 2'd3) begin
                     hex_digits = hex_digits + 2'd1;
                  end else if (scan_mode == ST_HEX) begin
                     take_value(hex_acc);
                  end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                     emit_cp('h10000 + (int'(pending_high) << 10) + (int'(hex_acc) - 'hDC00));
                     hex_acc = 16'h0000;
                     hex_digits = 2'd0;
                     pending_high = 10'h000;
                     scan_mode = ST_TEXT;
                  end else begin
                     emit_high();
                     take_value(hex_acc);
                  end
               end
            end
         end
         ST_PEND: begin
            if (c == CHAR_BSLASH && !fin) begin
               scan_mode = ST_PEND_BS;
            end else begin
               emit_high();
               pending_high = 10'h000;
               scan_mode = ST_TEXT;
               in_text(c);
            end
         end
         ST_PEND_BS: begin
            if (c == CHAR_U) begin
               scan_mode = ST_LOWHEX;
               hex_acc = 16'h0000;
               hex_digits = 2'd0;
            end
            if (c != CHAR_U || fin) begin
               emit_high();
               pending_high = 10'h000;
               scan_mode = ST_ESC;
               in_escape(c);
            end
         end
         default: clear_scan();
      endcase
      if (fin && scan_mode != ST_IDLE) begin
         if (scan_mode == ST_PEND || scan_mode == ST_LOWHEX) emit_high();
         abort_string(ERR_ENDED);
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      decoded_expected = {decoded_expected, step_out};
   endfunction

   // ---------------------------------------------------------------- result side

   function automatic void check_result();
      decoded_type exp_r;
      if (decoded_expected.size() == 0) begin
         $error("result with nothing expected: byte %0h kind %0d code %0d last %0b",
                rsp_out_byte, rsp_out_kind, rsp_err_code, rsp_last);
         fail_count++;
      end else begin
         exp_r = decoded_expected.pop_front();
         if (rsp_out_byte !== exp_r.data) begin
            $error("rsp_out_byte: expected %0h, got %0h", exp_r.data, rsp_out_byte);
            fail_count++;
         end
         if (rsp_out_kind !== exp_r.kind) begin
            $error("rsp_out_kind: expected %0d, got %0d", exp_r.kind, rsp_out_kind);
            fail_count++;
         end
         if (rsp_err_code !== exp_r.code) begin
            $error("rsp_err_code: expected %0d, got %0d", exp_r.code, rsp_err_code);
            fail_count++;
         end
         if (rsp_last !== exp_r.last) begin
            $error("rsp_last: expected %0b, got %0b", exp_r.last, rsp_last);
            fail_count++;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         rx_phase <= 4'd0;
      end else begin
         if (pop && !empty) check_result();
         rx_phase <= rx_phase + 4'd1;
         if (rx_hold) begin
            pop <= 1'b0;
         end else begin
            case (rx_style)
               RX_READY:   pop <= 1'b1;
               RX_PATTERN: pop <= rx_pattern[rx_phase];
               default:    pop <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Long hold-off of the receiver, started by the back-pressure test
   always begin
      @(hold_trigger);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------- input side

   task automatic send_byte(input logic [7:0] c, input bit fin);
      if (tx_bursty) begin
         if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      req_in_byte <= c;
      req_end_of_input <= fin;
      push <= 1'b1;
      do @(posedge clock); while (full);
      unescape_byte(c, fin);
      items_sent++;
   endtask

   // Text byte, now and then marked as the end of input
   task automatic send_txt(input logic [7:0] c);
      send_byte(c, end_rate != 0 && $urandom_range(0, end_rate - 1) == 0);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return "0" + n;
      return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (hex_val(b) >= 0);
      return b;
   endfunction

   function automatic logic [15:0] rand_unit(input bit allow_low);
      case ($urandom_range(0, allow_low ? 5 : 4))
         0:       return 16'($urandom_range(0, 'h7F));
         1:       return 16'($urandom_range('h80, 'h7FF));
         2:       return 16'($urandom_range('h800, 'hD7FF));
         3:       return 16'($urandom_range('hE000, 'hFFFF));
         4:       return 16'($urandom_range('hD800, 'hDBFF));
         default: return 16'($urandom_range('hDC00, 'hDFFF));
      endcase
   endfunction

   task automatic send_uesc(input logic [15:0] v);
      send_txt(CHAR_BSLASH);
      send_txt(CHAR_U);
      for (int i = 3; i >= 0; i--) send_txt(hex_char(v[i*4 +: 4]));
   endtask

   task automatic send_bad_hex();
      send_txt(CHAR_BSLASH);
      send_txt(CHAR_U);
      repeat ($urandom_range(0, 3)) send_txt(hex_char(4'($urandom)));
      send_txt(non_hex_byte());
   endtask

   task automatic send_plain();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_QUOTE || b == CHAR_BSLASH) b ^= 8'h01;
      send_txt(b);
   endtask

   task automatic rand_token();
      case ($urandom_range(0, 15))
         0, 1, 2, 3, 4: send_plain();
         5, 6, 7: begin
            send_txt(CHAR_BSLASH);
            send_txt(esc_chars[$urandom_range(0, 7)]);
         end
         8, 9: send_uesc(rand_unit(1'b1));
         10, 11, 12: begin
            send_uesc(16'($urandom_range('hD800, 'hDBFF)));
            send_uesc(16'($urandom_range('hDC00, 'hDFFF)));
         end
         13: begin
            // high surrogate left without its low half
            send_uesc(16'($urandom_range('hD800, 'hDBFF)));
            case ($urandom_range(0, 3))
               0: send_uesc(rand_unit(1'b0));
               1: send_plain();
               2: send_bad_hex();
               default: begin
                  send_txt(CHAR_BSLASH);
                  send_txt(8'($urandom_range(0, 255)));
               end
            endcase
         end
         14: begin
            send_txt(CHAR_BSLASH);
            send_txt(8'($urandom_range(0, 255)));
         end
         default: send_bad_hex();
      endcase
   endtask

   task automatic random_string();
      send_txt(CHAR_QUOTE);
      repeat ($urandom_range(0, 10)) rand_token();
      if ($urandom_range(0, 9) != 0) send_txt(CHAR_QUOTE);
      else send_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_idle_noise();
      send_byte(8'hFF, 1'b0);
   endtask

   task automatic test_plain_and_bad_escape();
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(CHAR_BSLASH, 1'b0);
      send_byte("t", 1'b0);
      send_byte(CHAR_BSLASH, 1'b0);
      send_byte("x", 1'b0);
   endtask

   task automatic test_surrogate_pair();
      send_byte(CHAR_QUOTE, 1'b0);
      send_uesc(16'hDBFF);
      send_uesc(16'hDFFF);
      send_byte(CHAR_QUOTE, 1'b0);
   endtask

   task automatic test_bad_hex();
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(CHAR_BSLASH, 1'b0);
      send_byte(CHAR_U, 1'b0);
      send_byte("g", 1'b0);
   endtask

   task automatic test_ended_early();
      send_byte(CHAR_QUOTE, 1'b1);
   endtask

   // Hold the receiver off while bytes keep coming, so the block fills and stalls
   task automatic test_backpressure();
      tx_bursty = 1'b0;
      rx_style <= RX_READY;
      -> hold_trigger;
      send_byte(CHAR_QUOTE, 1'b0);
      repeat (20) send_byte(8'($urandom_range('h23, 'h5B)), 1'b0);
      send_byte(CHAR_QUOTE, 1'b0);
   endtask

   task automatic test_random_strings(input int count);
      int stop_at;
      stop_at = items_sent + count;
      end_rate = 60;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 7) == 0) begin
            tx_bursty = 1'($urandom_range(0, 1));
            rx_style <= rx_style_type'($urandom_range(0, 2));
            rx_pattern <= 16'($urandom) | 16'h8001;
         end
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3))
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         end
         random_string();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_idle_noise();
      test_plain_and_bad_escape();
      test_surrogate_pair();
      test_bad_hex();
      test_ended_early();
      test_backpressure();
      test_random_strings(RANDOM_ITEMS);
      push <= 1'b0;
      while (decoded_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
